[sv/bcre_pkg.sv]
// types and constants shared by the button click/repeat event block
package bcre_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ADDR_W = 2;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_DOUBLE_CLICK = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_REPEAT_DELAY = 2'd2;
    localparam logic [ADDR_W-1:0] CFG_REPEAT_INTVL = 2'd3;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [CFG_W-1:0] RST_DOUBLE_CLICK = 16'd500;
    localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = 16'd1000;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTVL = 16'd250;

    // input kinds and buttons
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic BTN_A     = 1'b0;
    localparam logic BTN_B     = 1'b1;
    localparam logic LVL_DOWN  = 1'b1;

    typedef enum logic [1:0] {
        MSG_DOWN   = 2'd0,
        MSG_UP     = 2'd1,
        MSG_DBL    = 2'd2,
        MSG_REPEAT = 2'd3
    } t_msg;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_click_ms;
        logic [CFG_W-1:0] repeat_delay_ms;
        logic [CFG_W-1:0] repeat_interval_ms;
    } t_cfg;

    // one classified request: first message plus a flag for a trailing double click
    typedef struct packed {
        t_msg              msg;
        logic              button;
        logic [TIME_W-1:0] held_ms;
        logic              dbl;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[sv/button_click_repeat_events_core.sv]
// top level of the two-button click, double-click and auto-repeat message generator
//
// Each request is either a timestamped edge of button A or B or a repeat-check tick.
// The front end takes one request every cycle while its queue has room: it applies the
// shared debounce lockout, updates the button state and classifies the request in the
// same cycle, so state never lags the next request. Requests that produce messages go
// into a short queue (QUEUE_DEPTH entries). The back end drains the queue into a
// registered output stage, one message per cycle unless the output stalls: most requests
// give one message there, an A release that also completes a double click gives two
// (up, then double click). Sustained rate is one request per cycle while the output is
// accepted, lower for a stream of double clicks. Rejected edges and ticks that fire no
// repeat produce nothing. Each message passes the queue, then the output register.
// Configuration writes take effect on the next request and should be made while idle.
module button_click_repeat_events_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [bcre_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [bcre_pkg::CFG_W-1:0]    i_cfg_wdata,
    // request side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // pin_level[0], time_ms[32:1], zero
    input  logic [1:0]                    s_axis_tuser,  // kind[0], which_button[1]
    // message side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // held_ms[31:0]
    output logic [2:0]                    m_axis_tuser,  // message[1:0], button[2]
    output logic                          m_axis_tlast
);

    bcre_pkg::t_cfg      r_cfg;
    bcre_pkg::t_job      push_job, head_job;
    bcre_pkg::t_q_status q_status;
    bcre_pkg::t_msg      out_msg;
    logic                push, pop, out_button;

    // configuration registers, all 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= bcre_pkg::RST_DEBOUNCE;
            r_cfg.double_click_ms    <= bcre_pkg::RST_DOUBLE_CLICK;
            r_cfg.repeat_delay_ms    <= bcre_pkg::RST_REPEAT_DELAY;
            r_cfg.repeat_interval_ms <= bcre_pkg::RST_REPEAT_INTVL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bcre_pkg::CFG_DEBOUNCE:     r_cfg.debounce_ms        <= i_cfg_wdata;
                bcre_pkg::CFG_DOUBLE_CLICK: r_cfg.double_click_ms    <= i_cfg_wdata;
                bcre_pkg::CFG_REPEAT_DELAY: r_cfg.repeat_delay_ms    <= i_cfg_wdata;
                bcre_pkg::CFG_REPEAT_INTVL: r_cfg.repeat_interval_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify and update button state
    bcre_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .i_kind         (s_axis_tuser[0]),
        .i_which_button (s_axis_tuser[1]),
        .i_pin_level    (s_axis_tdata[0]),
        .i_time_ms      (s_axis_tdata[32:1]),
        .i_q_full       (q_status.full),
        .o_ready        (s_axis_tready),
        .o_push         (push),
        .o_job          (push_job)
    );

    // decouples classification from message delivery
    bcre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // message expansion and output register
    bcre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_empty (q_status.empty),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_msg     (out_msg),
        .o_button  (out_button),
        .o_held_ms (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = {out_button, out_msg};

endmodule

[sv/bcre_front.sv]
// front end: debounce lockout, button state and classification of each request
module bcre_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcre_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    input  logic                       i_kind,
    input  logic                       i_which_button,
    input  logic                       i_pin_level,
    input  logic [bcre_pkg::TIME_W-1:0] i_time_ms,
    input  logic                       i_q_full,
    output logic                       o_ready,
    output logic                       o_push,
    output bcre_pkg::t_job             o_job
);

    logic [bcre_pkg::TIME_W-1:0] r_last_edge, n_last_edge;
    logic                        r_a_pending, n_a_pending;
    logic [bcre_pkg::TIME_W-1:0] r_a_release, n_a_release;
    logic                        r_b_held, n_b_held;
    logic [bcre_pkg::TIME_W-1:0] r_b_press, n_b_press;
    logic [bcre_pkg::TIME_W-1:0] r_b_repeat, n_b_repeat;

    logic [bcre_pkg::TIME_W-1:0] dt_edge, dt_a, dt_press, dt_repeat;
    logic                        accept, edge_ok, repeat_ok;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // all differences are modulo 2^32
    assign dt_edge   = i_time_ms - r_last_edge;
    assign dt_a      = i_time_ms - r_a_release;
    assign dt_press  = i_time_ms - r_b_press;
    assign dt_repeat = i_time_ms - r_b_repeat;

    assign edge_ok = dt_edge > {16'd0, i_cfg.debounce_ms};
    assign repeat_ok = r_b_held
                    && (dt_press >= {16'd0, i_cfg.repeat_delay_ms})
                    && (dt_repeat >= {16'd0, i_cfg.repeat_interval_ms});

    always_comb begin
        n_last_edge = r_last_edge;
        n_a_pending = r_a_pending;
        n_a_release = r_a_release;
        n_b_held    = r_b_held;
        n_b_press   = r_b_press;
        n_b_repeat  = r_b_repeat;
        o_push      = 1'b0;
        o_job.msg     = bcre_pkg::MSG_DOWN;
        o_job.button  = bcre_pkg::BTN_A;
        o_job.held_ms = '0;
        o_job.dbl     = 1'b0;
        if (accept) begin
            if (i_kind == bcre_pkg::KIND_TICK) begin
                if (repeat_ok) begin
                    o_push        = 1'b1;
                    o_job.msg     = bcre_pkg::MSG_REPEAT;
                    o_job.button  = bcre_pkg::BTN_B;
                    o_job.held_ms = dt_press;
                    n_b_repeat    = i_time_ms;
                end
            end else if (edge_ok) begin
                n_last_edge = i_time_ms;
                if (i_which_button == bcre_pkg::BTN_A) begin
                    o_push = 1'b1;
                    if (i_pin_level == bcre_pkg::LVL_DOWN) begin
                        o_job.msg = bcre_pkg::MSG_DOWN;
                    end else begin
                        o_job.msg = bcre_pkg::MSG_UP;
                        if (r_a_pending && (dt_a < {16'd0, i_cfg.double_click_ms})) begin
                            o_job.dbl   = 1'b1;
                            n_a_pending = 1'b0;
                        end else begin
                            n_a_pending = 1'b1;
                            n_a_release = i_time_ms;
                        end
                    end
                end else begin
                    if (i_pin_level == bcre_pkg::LVL_DOWN) begin
                        if (!r_b_held) begin
                            n_b_held   = 1'b1;
                            n_b_press  = i_time_ms;
                            n_b_repeat = i_time_ms;
                        end
                    end else if (r_b_held) begin
                        n_b_held     = 1'b0;
                        o_push       = 1'b1;
                        o_job.msg    = bcre_pkg::MSG_UP;
                        o_job.button = bcre_pkg::BTN_B;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_a_pending <= 1'b0;
            r_a_release <= '0;
            r_b_held    <= 1'b0;
            r_b_press   <= '0;
            r_b_repeat  <= '0;
        end else begin
            r_last_edge <= n_last_edge;
            r_a_pending <= n_a_pending;
            r_a_release <= n_a_release;
            r_b_held    <= n_b_held;
            r_b_press   <= n_b_press;
            r_b_repeat  <= n_b_repeat;
        end
    end

endmodule

[sv/bcre_queue.sv]
// small register queue of classified requests between front and back
module bcre_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bcre_pkg::t_job      i_job,
    input  logic                i_pop,
    output bcre_pkg::t_job      o_job,
    output bcre_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bcre_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/bcre_back.sv]
// back end: expands each queued request into one or two messages in an output register
module bcre_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bcre_pkg::t_job              i_job,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output bcre_pkg::t_msg              o_msg,
    output logic                        o_button,
    output logic [bcre_pkg::TIME_W-1:0] o_held_ms,
    output logic                        o_last
);

    logic                        r_valid, n_valid;
    logic                        r_dbl_due, n_dbl_due;
    bcre_pkg::t_msg              r_msg, n_msg;
    logic                        r_button, n_button;
    logic [bcre_pkg::TIME_W-1:0] r_held, n_held;
    logic                        r_last, n_last;
    logic                        slot_free;

    assign slot_free = !r_valid || i_tready;

    always_comb begin
        n_valid   = r_valid;
        n_dbl_due = r_dbl_due;
        n_msg     = r_msg;
        n_button  = r_button;
        n_held    = r_held;
        n_last    = r_last;
        o_pop     = 1'b0;
        if (slot_free) begin
            if (r_dbl_due) begin
                n_valid   = 1'b1;
                n_dbl_due = 1'b0;
                n_msg     = bcre_pkg::MSG_DBL;
                n_button  = bcre_pkg::BTN_A;
                n_held    = '0;
                n_last    = 1'b1;
            end else if (!i_q_empty) begin
                o_pop     = 1'b1;
                n_valid   = 1'b1;
                n_dbl_due = i_job.dbl;
                n_msg     = i_job.msg;
                n_button  = i_job.button;
                n_held    = i_job.held_ms;
                n_last    = !i_job.dbl;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_dbl_due <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_dbl_due <= n_dbl_due;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg    <= n_msg;
        r_button <= n_button;
        r_held   <= n_held;
        r_last   <= n_last;
    end

    assign o_tvalid  = r_valid;
    assign o_msg     = r_msg;
    assign o_button  = r_button;
    assign o_held_ms = r_held;
    assign o_last    = r_last;

endmodule
